### src/lma_pkg.sv
// shared types, constants and the microcode table of the liouville/mobius unit
package lma_pkg;

  // payload geometry
  localparam int IN_W  = 32;
  localparam int OUT_W = 80;
  localparam int SUM_W = 34;
  localparam int CNT_W = 6;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // two-bit signed codes of the per-item values
  localparam logic [1:0] VAL_ZERO  = 2'b00;
  localparam logic [1:0] VAL_PLUS  = 2'b01;
  localparam logic [1:0] VAL_MINUS = 2'b11;

  // datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR_HIT,
    OP_DIV_START,
    OP_TAKE_QUOT,
    OP_NEXT_DIV,
    OP_TAIL,
    OP_EMIT
  } op_t;

  // jump condition of one microcode step
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_SQ_GT_REST,
    C_DIV_BUSY,
    C_REM_NZ,
    C_OUT_FULL
  } cond_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // program addresses
  localparam step_t ST_WAIT   = 4'd0;
  localparam step_t ST_TEST   = 4'd1;
  localparam step_t ST_DSTART = 4'd2;
  localparam step_t ST_DRUN   = 4'd3;
  localparam step_t ST_CHECK  = 4'd4;
  localparam step_t ST_TAKE   = 4'd5;
  localparam step_t ST_NEXT   = 4'd6;
  localparam step_t ST_TAIL   = 4'd7;
  localparam step_t ST_EMIT   = 4'd8;
  localparam step_t ST_DONE   = 4'd9;

  // microcode rom: on a true condition go to target, else fall through
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      ST_WAIT:   w = '{OP_LOAD,      C_NO_INPUT,   ST_WAIT};
      ST_TEST:   w = '{OP_CLR_HIT,   C_SQ_GT_REST, ST_TAIL};
      ST_DSTART: w = '{OP_DIV_START, C_NEXT,       ST_WAIT};
      ST_DRUN:   w = '{OP_NONE,      C_DIV_BUSY,   ST_DRUN};
      ST_CHECK:  w = '{OP_NONE,      C_REM_NZ,     ST_NEXT};
      ST_TAKE:   w = '{OP_TAKE_QUOT, C_ALWAYS,     ST_DSTART};
      ST_NEXT:   w = '{OP_NEXT_DIV,  C_ALWAYS,     ST_TEST};
      ST_TAIL:   w = '{OP_TAIL,      C_NEXT,       ST_WAIT};
      ST_EMIT:   w = '{OP_EMIT,      C_OUT_FULL,   ST_EMIT};
      ST_DONE:   w = '{OP_NONE,      C_ALWAYS,     ST_WAIT};
      default:   w = '{OP_NONE,      C_ALWAYS,     ST_WAIT};
    endcase
    return w;
  endfunction

  // saturating add of a value in {-1, 0, +1}
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] acc,
                                                      input logic [1:0] delta);
    logic signed [SUM_W-1:0] r;
    r = acc;
    if (delta == VAL_PLUS && acc != SUM_MAX) begin
      r = acc + SUM_W'(1);
    end else if (delta == VAL_MINUS && acc != SUM_MIN) begin
      r = acc - SUM_W'(1);
    end
    return r;
  endfunction

endpackage

### src/lma_divider.sv
// restoring divider, one quotient bit per cycle
module lma_divider #(
  parameter int NB = 32,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NB-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NB-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CW = $clog2(NB + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NB-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  // one shift-subtract step
  always_comb begin
    rem_sh  = {rem_r, q_r[NB-1]};
    diff    = rem_sh - {1'b0, divisor};
    ge      = rem_sh >= {1'b0, divisor};
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CW'(NB);
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CW'(1);
      q_nxt   = {q_r[NB-2:0], ge};
      rem_nxt = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  // iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // quotient and remainder
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = cnt_r != '0;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

### src/liouville_mobius_accumulator_unit.sv
// top level: trial-division factoring with liouville and mertens running sums
//
// Each input word carries one number; its low NUMBER_BITS bits are factored by
// trial division with divisors 2, 3, 4, ... while the divisor squared does not
// exceed the remaining cofactor, and one result word follows with the liouville
// value, the mobius value, the factor count with multiplicity and both running
// sums (saturating 34-bit, cleared by reset). A zero number yields zero values
// and leaves the sums alone. One number is in work at a time; a new word is
// taken once the previous result has been placed in the output register. Time
// per number is set by the shared restoring divider, which works out one
// remainder for each divisor tried and one more for each prime factor removed.
// The worst case is a prime just below 2^32.
module liouville_mobius_accumulator_unit #(
  parameter int NUMBER_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [lma_pkg::IN_W-1:0]  in_tdata,   // [31:0] number
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [1:0] liouville_value, [3:2] mobius_value, [9:4] factor_count,
  // [43:10] liouville_total, [77:44] mertens_total, [79:78] zero
  output logic [lma_pkg::OUT_W-1:0] out_tdata
);
  import lma_pkg::*;

  localparam int NB  = NUMBER_BITS;
  localparam int DW  = NUMBER_BITS / 2 + 2;
  localparam int SQW = NUMBER_BITS + 2;
  localparam int INW = (NUMBER_BITS < IN_W) ? NUMBER_BITS : IN_W;

  step_t                   step_r, step_nxt;
  uword_t                  uw;
  logic                    jmp;
  logic [NB-1:0]           rest_r, rest_nxt;
  logic [DW-1:0]           d_r, d_nxt;
  logic [SQW-1:0]          sq_r, sq_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    hit_r, hit_nxt;
  logic                    sqfree_r, sqfree_nxt;
  logic                    zero_r, zero_nxt;
  logic signed [SUM_W-1:0] lsum_r, lsum_nxt;
  logic signed [SUM_W-1:0] msum_r, msum_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        out_data_r, out_data_nxt;
  logic [NB-1:0]           num;
  logic                    in_acc;
  logic                    out_full;
  logic                    div_start;
  logic                    div_busy;
  logic [NB-1:0]           div_quot;
  logic [DW-1:0]           div_rem;
  logic [1:0]              lv;
  logic [1:0]              mv;

  // shared remainder unit
  lma_divider #(
    .NB (NB),
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rest_r),
    .divisor   (d_r),
    .busy      (div_busy),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // control word fetch and handshake
  always_comb begin
    uw        = ucode(step_r);
    num       = NB'(in_tdata[INW-1:0]);
    in_tready = uw.op == OP_LOAD;
    in_acc    = in_tvalid && in_tready;
    out_full  = out_valid_r && !out_tready;
    div_start = uw.op == OP_DIV_START;
  end

  // jump condition and next step
  always_comb begin
    case (uw.cond)
      C_NEXT:       jmp = 1'b0;
      C_ALWAYS:     jmp = 1'b1;
      C_NO_INPUT:   jmp = !in_tvalid;
      C_SQ_GT_REST: jmp = sq_r > SQW'(rest_r);
      C_DIV_BUSY:   jmp = div_busy;
      C_REM_NZ:     jmp = div_rem != '0;
      C_OUT_FULL:   jmp = out_full;
      default:      jmp = 1'b1;
    endcase
    step_nxt = jmp ? uw.target : step_r + step_t'(1);
  end

  // per-item values from the finished factorization
  always_comb begin
    lv = count_r[0] ? VAL_MINUS : VAL_PLUS;
    mv = sqfree_r ? lv : VAL_ZERO;
    if (zero_r) begin
      lv = VAL_ZERO;
      mv = VAL_ZERO;
    end
  end

  // datapath driven by the control word
  always_comb begin
    rest_nxt      = rest_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    count_nxt     = count_r;
    hit_nxt       = hit_r;
    sqfree_nxt    = sqfree_r;
    zero_nxt      = zero_r;
    lsum_nxt      = lsum_r;
    msum_nxt      = msum_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (uw.op)
      OP_LOAD: begin
        if (in_acc) begin
          rest_nxt   = num;
          d_nxt      = DW'(2);
          sq_nxt     = SQW'(4);
          count_nxt  = '0;
          sqfree_nxt = 1'b1;
          zero_nxt   = num == '0;
        end
      end
      OP_CLR_HIT: begin
        hit_nxt = 1'b0;
      end
      OP_TAKE_QUOT: begin
        rest_nxt  = div_quot;
        count_nxt = count_r + CNT_W'(1);
        hit_nxt   = 1'b1;
        if (hit_r) begin
          sqfree_nxt = 1'b0;
        end
      end
      OP_NEXT_DIV: begin
        d_nxt  = d_r + DW'(1);
        sq_nxt = sq_r + SQW'({d_r, 1'b1});
      end
      OP_TAIL: begin
        if (rest_r > NB'(1)) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_EMIT: begin
        if (!out_full) begin
          lsum_nxt      = sat_add(lsum_r, lv);
          msum_nxt      = sat_add(msum_r, mv);
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, msum_nxt, lsum_nxt, count_r, mv, lv};
        end
      end
      default: begin
      end
    endcase
  end

  // control state and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_WAIT;
      lsum_r      <= '0;
      msum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      lsum_r      <= lsum_nxt;
      msum_r      <= msum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rest_r     <= rest_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    count_r    <= count_nxt;
    hit_r      <= hit_nxt;
    sqfree_r   <= sqfree_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### src/lma_checker.sv
// port-level checks of the liouville/mobius unit, bound to the top level
module lma_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [lma_pkg::OUT_W-1:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // liouville value is never the unused code
  a_lv_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'b10)
    else $error("bad liouville code");

  // a zero number gives zero mobius value and zero count
  a_zero_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == 2'b00 |-> out_tdata[9:2] == 8'd0)
    else $error("zero item with nonzero fields");

  // liouville sign follows factor count parity
  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'b00 |-> (out_tdata[1:0] == 2'b11) == out_tdata[4])
    else $error("liouville value does not match count parity");

  // a nonzero mobius value equals the liouville value
  a_mobius: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:2] != 2'b00 |-> out_tdata[3:2] == out_tdata[1:0])
    else $error("mobius value disagrees with liouville value");

endmodule

bind liouville_mobius_accumulator_unit lma_checker u_lma_checker (.*);

### tb/testbench.sv
// testbench of the liouville/mobius unit: factoring checks against a local predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lma_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam int RANDOM_NUMBERS = 78;

  // expected content of one result word
  typedef struct {
    logic [1:0]              liouville;
    logic [1:0]              mobius;
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] liouville_total;
    logic signed [SUM_W-1:0] mertens_total;
  } factor_result_t;

  // factors each accepted number and keeps the running sums
  class factor_scoreboard;
    logic signed [SUM_W-1:0] liouville_run;
    logic signed [SUM_W-1:0] mertens_run;
    factor_result_t          pending[$];

    function new();
      liouville_run = '0;
      mertens_run   = '0;
    endfunction

    // clamp to the 34-bit signed range
    function logic signed [SUM_W-1:0] bump(logic signed [SUM_W-1:0] acc, int delta);
      longint t;
      t = longint'(acc) + delta;
      if (t > longint'(SUM_MAX)) t = longint'(SUM_MAX);
      if (t < longint'(SUM_MIN)) t = longint'(SUM_MIN);
      return t[SUM_W-1:0];
    endfunction

    function void note_number(logic [IN_W-1:0] number);
      factor_result_t  r;
      longint unsigned rest;
      longint unsigned d;
      int              mult;
      int              omega;
      bit              squarefree;
      r.liouville = VAL_ZERO;
      r.mobius    = VAL_ZERO;
      r.count     = '0;
      // zero has no factorization and leaves the sums alone
      if (number != '0) begin
        rest       = number;
        omega      = 0;
        squarefree = 1'b1;
        for (d = 2; d * d <= rest; d++) begin
          mult = 0;
          while (rest % d == 0) begin
            rest = rest / d;
            mult++;
          end
          if (mult >= 2) squarefree = 1'b0;
          omega += mult;
        end
        // leftover cofactor is one more prime
        if (rest > 1) omega++;
        r.liouville   = omega[0] ? VAL_MINUS : VAL_PLUS;
        r.mobius      = squarefree ? r.liouville : VAL_ZERO;
        r.count       = omega[CNT_W-1:0];
        liouville_run = bump(liouville_run, omega[0] ? -1 : 1);
        mertens_run   = bump(mertens_run, !squarefree ? 0 : (omega[0] ? -1 : 1));
      end
      r.liouville_total = liouville_run;
      r.mertens_total   = mertens_run;
      pending.push_back(r);
    endfunction

    // returns the number of wrong fields, with a description
    function int check_word(logic [OUT_W-1:0] word, output string why);
      factor_result_t e;
      int             bad;
      bad = 0;
      why = "";
      if (pending.size() == 0) begin
        why = $sformatf("word %h with nothing pending", word);
        return 1;
      end
      e = pending.pop_front();
      if (word[1:0] !== e.liouville) begin
        bad++;
        why = {why, $sformatf(" liouville %b exp %b", word[1:0], e.liouville)};
      end
      if (word[3:2] !== e.mobius) begin
        bad++;
        why = {why, $sformatf(" mobius %b exp %b", word[3:2], e.mobius)};
      end
      if (word[9:4] !== e.count) begin
        bad++;
        why = {why, $sformatf(" count %0d exp %0d", word[9:4], e.count)};
      end
      if (word[43:10] !== e.liouville_total) begin
        bad++;
        why = {why, $sformatf(" liouville_total %h exp %h", word[43:10], e.liouville_total)};
      end
      if (word[77:44] !== e.mertens_total) begin
        bad++;
        why = {why, $sformatf(" mertens_total %h exp %h", word[77:44], e.mertens_total)};
      end
      if (word[79:78] !== 2'b00) begin
        bad++;
        why = {why, $sformatf(" pad %b", word[79:78])};
      end
      return bad;
    endfunction
  endclass

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  factor_scoreboard sb = new();
  int               mismatches = 0;
  int               idle_cycles = 0;
  bit               in_burst = 1'b0;
  bit               out_burst = 1'b0;

  liouville_mobius_accumulator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch:%s", $realtime, msg);
    mismatches++;
  endtask

  // wait before the next word, with runs of back-to-back words
  function automatic int next_gap(ref bit burst);
    if ($urandom_range(0, 15) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  // random numbers, kept cheap to factor but spread over all bits
  function automatic logic [IN_W-1:0] draw_number();
    longint unsigned p;
    int              f;
    int              kind;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // product of small factors
      p = 1;
      repeat ($urandom_range(1, 24)) begin
        f = $urandom_range(2, 61);
        if (p * f <= 64'hFFFF_FFFF) p = p * f;
      end
      return p[IN_W-1:0];
    end else if (kind < 78) begin
      return IN_W'($urandom_range(1, 255)) << $urandom_range(0, 24);
    end else if (kind < 92) begin
      return IN_W'($urandom_range(1, 4095));
    end else if (kind < 97) begin
      return IN_W'($urandom_range(4096, 65535));
    end
    return '0;
  endfunction

  task automatic send_number(logic [IN_W-1:0] number);
    int gap;
    gap = next_gap(in_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= number;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_number(number);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // result side with random stalls
  initial begin
    int    gap;
    int    bad;
    string why;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = next_gap(out_burst);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      bad = sb.check_word(out_tdata, why);
      if (bad != 0) report_mismatch(why);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("liouville_mobius_accumulator_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    logic [IN_W-1:0] directed[$];
    directed = '{
      32'd0,          // zero gives zero values and leaves the sums alone
      32'd1,          // no prime factors
      32'd2, 32'd3, 32'd4, 32'd6, 32'd8, 32'd9, 32'd12, 32'd30, 32'd36, 32'd210,
      32'd0,          // zero again, liouville sum now nonzero
      32'hFFFF_FFFF,  // 3*5*17*257*65537
      32'h8000_0000,  // 2^31, most factors that fit
      32'hAAAA_AAAA,
      32'hFFFF_0000,
      32'd3486784401, // 3^20
      32'd65521,      // prime below 2^16
      32'd1048573,    // prime below 2^20, slowest word of the run
      32'd223092870,  // product of the first nine primes
      32'd65537
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_number(directed[i]);
    // hold off until every result is back
    in_tvalid <= 1'b0;
    wait_drained();

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (i == 45) begin
        in_tvalid <= 1'b0;
        wait_drained();
      end
      send_number(draw_number());
    end
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("liouville_mobius_accumulator_unit test passed");
    end else begin
      $display("liouville_mobius_accumulator_unit test failed");
    end
    $finish;
  end

endmodule
